// ----- rtl/replacement_curve_point_generator_defines.svh -----
// Assertion macros shared by the curve point generator.
`ifndef REPLACEMENT_CURVE_POINT_GENERATOR_DEFINES_SVH
`define REPLACEMENT_CURVE_POINT_GENERATOR_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define RCPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define RCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/rcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// rcpg_pkg
// Types and constants of the curve point generator.
// ----------------------------------------------------------------------------
package rcpg_pkg;
    localparam int TableDepth = 512;
    localparam int MaxLevels  = 16;
    localparam int CoordWidth = 32;
    localparam int FracBits   = 24;
    localparam int OutWidth   = 32;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_NEXT    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic REG_STEP_COUNT  = 1'b0;
    localparam logic REG_DEPTH_LIMIT = 1'b1;

    // States of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } t_mul_state;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_WAIT,
        ST_M_DY,
        ST_M_UXCX,
        ST_M_UYCY,
        ST_M_UYCX,
        ST_M_UXCY,
        ST_M_UXDX,
        ST_M_UYDY,
        ST_M_UYDX,
        ST_M_UXDY,
        ST_M_SCALE,
        ST_COMMIT,
        ST_OUT
    } t_seq_state;
endpackage

// ----- rtl/rcpg_ram.sv -----
// ----------------------------------------------------------------------------
// rcpg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcpg_ram #(
    parameter int Width = 32,
    parameter int Depth = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rcpg_mul.sv -----
// ----------------------------------------------------------------------------
// rcpg_mul
// Shared saturating fixed-point multiplier: magnitudes are multiplied in
// 16 by 16 bit partial products, one per cycle, then rounded and saturated.
// ----------------------------------------------------------------------------
module rcpg_mul #(
    parameter int CoordWidth = rcpg_pkg::CoordWidth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [CoordWidth-1:0] i_a,
    input  logic signed [CoordWidth-1:0] i_b,
    output logic                         o_done,
    output logic signed [CoordWidth-1:0] o_p
);
    localparam int Chunks = (CoordWidth + 15) / 16;
    localparam int MagW   = Chunks * 16;
    localparam int ProdW  = 2 * MagW;
    localparam int Steps  = Chunks * Chunks;
    localparam int CntW   = $clog2(Steps + 1);
    localparam int ChW    = (Chunks > 1) ? $clog2(Chunks) : 1;

    rcpg_pkg::t_mul_state r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [ChW-1:0]   r_ia, n_ia, r_ib, n_ib;
    logic [MagW-1:0]  r_ma, r_mb;
    logic             r_neg;
    logic [ProdW-1:0] r_acc, n_acc;

    logic [ChW-1:0]   w_ia, w_ib;
    logic [15:0]      w_pa, w_pb;
    logic [31:0]      w_prod;
    logic [ProdW-1:0] w_part;
    logic [ProdW-1:0] w_rnd;
    logic [ProdW-1:0] w_m;
    logic             w_over;
    logic signed [CoordWidth-1:0] w_res;

    function automatic logic [MagW-1:0] f_mag(input logic signed [CoordWidth-1:0] v);
        logic [MagW-1:0] e;
        e = MagW'(v);
        if (v[CoordWidth-1]) begin
            e = ~e + 1'b1;
        end
        return e;
    endfunction

    // Pick the chunk pair of the current step.
    assign w_ia   = r_ia;
    assign w_ib   = r_ib;
    assign w_pa   = r_ma[w_ia*16 +: 16];
    assign w_pb   = r_mb[w_ib*16 +: 16];
    assign w_prod = w_pa * w_pb;
    assign w_part = ProdW'(w_prod) << (16 * (int'(w_ia) + int'(w_ib)));

    // Round, then saturate to the coordinate range.
    assign w_rnd  = r_acc + (ProdW'(1) << (rcpg_pkg::FracBits - 1));
    assign w_m    = w_rnd >> rcpg_pkg::FracBits;
    assign w_over = |w_m[ProdW-1:CoordWidth-1];
    always_comb begin
        if (r_neg) begin
            w_res = w_over ? {1'b1, {(CoordWidth-1){1'b0}}}
                           : CoordWidth'(-$signed({1'b0, w_m[CoordWidth-2:0]}));
        end else begin
            w_res = w_over ? {1'b0, {(CoordWidth-1){1'b1}}}
                           : CoordWidth'(w_m[CoordWidth-2:0]);
        end
    end

    // Sequencer of the partial products.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_acc   = r_acc;
        case (r_state)
            rcpg_pkg::MUL_IDLE: begin
                if (i_start) begin
                    n_state = rcpg_pkg::MUL_RUN;
                    n_cnt   = '0;
                    n_ia    = '0;
                    n_ib    = '0;
                    n_acc   = '0;
                end
            end
            rcpg_pkg::MUL_RUN: begin
                n_acc = r_acc + w_part;
                n_cnt = r_cnt + 1'b1;
                if (r_ib == ChW'(Chunks - 1)) begin
                    n_ib = '0;
                    n_ia = r_ia + 1'b1;
                end else begin
                    n_ib = r_ib + 1'b1;
                end
                if (r_cnt == CntW'(Steps - 1)) begin
                    n_state = rcpg_pkg::MUL_DONE;
                end
            end
            rcpg_pkg::MUL_DONE: begin
                n_state = rcpg_pkg::MUL_IDLE;
            end
            default: n_state = rcpg_pkg::MUL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcpg_pkg::MUL_IDLE;
            r_cnt   <= '0;
            r_ia    <= '0;
            r_ib    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ia    <= n_ia;
            r_ib    <= n_ib;
        end
    end

    // Operand capture and accumulator.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_state == rcpg_pkg::MUL_IDLE && i_start) begin
            r_ma  <= f_mag(i_a);
            r_mb  <= f_mag(i_b);
            r_neg <= i_a[CoordWidth-1] ^ i_b[CoordWidth-1];
        end
    end

    assign o_done = (r_state == rcpg_pkg::MUL_DONE);
    assign o_p    = w_res;
endmodule

// ----- rtl/replacement_curve_point_generator.sv -----
// A next item runs ten products on the shared multiplier per level that it descends and
// five at the deepest level, pops levels in the check state and ends the walk with the
// endpoint. One item at a time.
// Reset (synchronous, active low) clears the frame stack, ends any walk and sets
// step count and depth limit to one; the step table is undefined until loaded.
// ----------------------------------------------------------------------------
// replacement_curve_point_generator
// Depth-first point generator of a self-similar curve with an explicit frame
// stack, built around one shared saturating multiplier.
// ----------------------------------------------------------------------------
`include "replacement_curve_point_generator_defines.svh"

module replacement_curve_point_generator #(
    parameter int TABLE_DEPTH = rcpg_pkg::TableDepth,
    parameter int MAX_LEVELS  = rcpg_pkg::MaxLevels,
    parameter int COORD_WIDTH = rcpg_pkg::CoordWidth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: step_index[8:0], step_dx[31:0], step_dy[31:0],
    // step_reverse, step_vscale[31:0], zero fill to 112 bits.
    input  logic [111:0] s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [1:0]   s_axis_tuser,
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: point_x[31:0], point_y[31:0].
    output logic [63:0]  m_axis_tdata,
    // tlast: last_point.
    output logic         m_axis_tlast,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [9:0]   i_cfg_wdata
);
    localparam int CW    = COORD_WIDTH;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW    = $clog2(TABLE_DEPTH + 1);
    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int EW    = 2 * CW + 1 + CW;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE =
        (CW - 1 > rcpg_pkg::FracBits) ? CW'(1) << rcpg_pkg::FracBits : CMAX;

    // Saturating add of two coordinates.
    function automatic logic signed [CW-1:0] f_sadd(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
        return s[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] f_ssub(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} - {b[CW-1], b};
        if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
        return s[CW-1:0];
    endfunction

    // Fit a 32 bit input into the coordinate width.
    function automatic logic signed [CW-1:0] f_in(input logic signed [31:0] v);
        logic signed [(CW>32?CW:32)-1:0] w;
        w = v;
        if (CW >= 32) return CW'(w);
        if (w > (CW>32?CW:32)'(CMAX)) return CMAX;
        if (w < (CW>32?CW:32)'(CMIN)) return CMIN;
        return CW'(w);
    endfunction

    // Saturate a coordinate to 32 output bits.
    function automatic logic [31:0] f_out(input logic signed [CW-1:0] v);
        logic signed [(CW>32?CW:32)-1:0] w;
        w = v;
        if (w > (CW>32?CW:32)'(32'sh7fffffff)) return 32'h7fffffff;
        if (w < -(CW>32?CW:32)'(33'sh080000000)) return 32'h80000000;
        return w[31:0];
    endfunction

    // Input field split.
    logic [1:0]  w_cmd;
    logic [8:0]  w_idx;
    logic [31:0] w_dx, w_dy, w_vs;
    logic        w_rev;
    assign w_cmd = s_axis_tuser;
    assign w_idx = s_axis_tdata[8:0];
    assign w_dx  = s_axis_tdata[40:9];
    assign w_dy  = s_axis_tdata[72:41];
    assign w_rev = s_axis_tdata[73];
    assign w_vs  = s_axis_tdata[105:74];

    // Configuration registers.
    logic [9:0] r_step_count;
    logic [3:0] r_depth_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count  <= 10'd1;
            r_depth_limit <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcpg_pkg::REG_STEP_COUNT:  r_step_count  <= i_cfg_wdata;
                rcpg_pkg::REG_DEPTH_LIMIT: r_depth_limit <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Clamped count and limit.
    logic [PW-1:0] w_n;
    logic [LW-1:0] w_dl;
    assign w_n  = (32'(r_step_count) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(r_step_count);
    assign w_dl = (32'(r_depth_limit) > MAX_LEVELS - 1) ? LW'(MAX_LEVELS - 1)
                                                       : LW'(r_depth_limit);

    // Frame stack, one register per level.
    logic [PW-1:0]        r_fpos [MAX_LEVELS];
    logic signed [CW-1:0] r_fcx [MAX_LEVELS], r_fcy [MAX_LEVELS];
    logic signed [CW-1:0] r_fox [MAX_LEVELS], r_foy [MAX_LEVELS];
    logic signed [CW-1:0] r_fux [MAX_LEVELS], r_fuy [MAX_LEVELS];
    logic                 r_fflip [MAX_LEVELS];
    logic signed [CW-1:0] r_fscale [MAX_LEVELS];
    logic [LW-1:0]        r_level;
    logic                 r_done;

    // Step table memory.
    logic          w_load;
    logic [AW-1:0] r_raddr;
    logic [EW-1:0] w_wentry, w_rentry;
    assign w_load   = s_axis_tvalid && s_axis_tready && w_cmd == rcpg_pkg::CMD_LOAD
                      && 32'(w_idx) < TABLE_DEPTH;
    assign w_wentry = {f_in(w_vs), w_rev, f_in(w_dy), f_in(w_dx)};

    rcpg_ram #(.Width(EW), .Depth(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(w_idx)),
        .i_wdata (w_wentry),
        .i_raddr (r_raddr),
        .o_rdata (w_rentry)
    );

    // Working registers of the current step.
    rcpg_pkg::t_seq_state r_state, n_state;
    logic signed [CW-1:0] r_tdx, r_tdy, r_tvs, r_dy;
    logic                 r_tflip;
    logic signed [CW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [CW-1:0] r_px, r_py;
    logic [31:0]          r_ox, r_oy;
    logic                 r_olast, r_ovalid;

    // Shared multiplier with its operand select.
    logic                 w_mstart, w_mdone;
    logic signed [CW-1:0] w_ma, w_mb, w_mp, w_factor;
    logic signed [CW-1:0] w_ux, w_uy, w_cx, w_cy;
    assign w_ux = r_fux[r_level];
    assign w_uy = r_fuy[r_level];
    assign w_cx = r_fcx[r_level];
    assign w_cy = r_fcy[r_level];
    assign w_factor = r_fflip[r_level]
        ? ((r_fscale[r_level] == CMIN) ? CMAX : -r_fscale[r_level]) : r_fscale[r_level];

    always_comb begin
        w_ma = w_ux;
        w_mb = w_cx;
        case (r_state)
            rcpg_pkg::ST_M_DY:    begin w_ma = r_tdy; w_mb = w_factor; end
            rcpg_pkg::ST_M_UXCX:  begin w_ma = w_ux; w_mb = w_cx; end
            rcpg_pkg::ST_M_UYCY:  begin w_ma = w_uy; w_mb = w_cy; end
            rcpg_pkg::ST_M_UYCX:  begin w_ma = w_uy; w_mb = w_cx; end
            rcpg_pkg::ST_M_UXCY:  begin w_ma = w_ux; w_mb = w_cy; end
            rcpg_pkg::ST_M_UXDX:  begin w_ma = w_ux; w_mb = r_tdx; end
            rcpg_pkg::ST_M_UYDY:  begin w_ma = w_uy; w_mb = r_dy; end
            rcpg_pkg::ST_M_UYDX:  begin w_ma = w_uy; w_mb = r_tdx; end
            rcpg_pkg::ST_M_UXDY:  begin w_ma = w_ux; w_mb = r_dy; end
            rcpg_pkg::ST_M_SCALE: begin w_ma = r_fscale[r_level]; w_mb = r_tvs; end
            default: ;
        endcase
    end

    logic r_mbusy;
    logic w_mstate;
    assign w_mstate = (r_state == rcpg_pkg::ST_M_DY) || (r_state == rcpg_pkg::ST_M_UXCX)
        || (r_state == rcpg_pkg::ST_M_UYCY) || (r_state == rcpg_pkg::ST_M_UYCX)
        || (r_state == rcpg_pkg::ST_M_UXCY) || (r_state == rcpg_pkg::ST_M_UXDX)
        || (r_state == rcpg_pkg::ST_M_UYDY) || (r_state == rcpg_pkg::ST_M_UYDX)
        || (r_state == rcpg_pkg::ST_M_UXDY) || (r_state == rcpg_pkg::ST_M_SCALE);
    assign w_mstart = w_mstate && !r_mbusy;

    rcpg_mul #(.CoordWidth(CW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    // Handshake.
    logic w_in_acc, w_out_acc;
    assign s_axis_tready = (r_state == rcpg_pkg::ST_IDLE) && !r_ovalid;
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    logic [AW-1:0] w_i;
    logic [PW-1:0] w_k;
    assign w_k = r_fpos[r_level];
    assign w_i = r_fflip[r_level] ? AW'(w_n - 1'b1 - w_k) : AW'(w_k);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcpg_pkg::ST_IDLE: begin
                if (w_in_acc && w_cmd == rcpg_pkg::CMD_NEXT && !r_done) begin
                    n_state = rcpg_pkg::ST_CHECK;
                end
            end
            rcpg_pkg::ST_CHECK: begin
                if (w_k >= w_n) begin
                    n_state = (r_level == '0) ? rcpg_pkg::ST_OUT : rcpg_pkg::ST_CHECK;
                end else begin
                    n_state = rcpg_pkg::ST_READ;
                end
            end
            rcpg_pkg::ST_READ:    n_state = rcpg_pkg::ST_WAIT;
            rcpg_pkg::ST_WAIT:    n_state = rcpg_pkg::ST_M_DY;
            rcpg_pkg::ST_M_DY:    if (w_mdone) n_state = rcpg_pkg::ST_M_UXCX;
            rcpg_pkg::ST_M_UXCX:  if (w_mdone) n_state = rcpg_pkg::ST_M_UYCY;
            rcpg_pkg::ST_M_UYCY:  if (w_mdone) n_state = rcpg_pkg::ST_M_UYCX;
            rcpg_pkg::ST_M_UYCX:  if (w_mdone) n_state = rcpg_pkg::ST_M_UXCY;
            rcpg_pkg::ST_M_UXCY: begin
                if (w_mdone) begin
                    n_state = (r_level < w_dl) ? rcpg_pkg::ST_M_UXDX : rcpg_pkg::ST_COMMIT;
                end
            end
            rcpg_pkg::ST_M_UXDX:  if (w_mdone) n_state = rcpg_pkg::ST_M_UYDY;
            rcpg_pkg::ST_M_UYDY:  if (w_mdone) n_state = rcpg_pkg::ST_M_UYDX;
            rcpg_pkg::ST_M_UYDX:  if (w_mdone) n_state = rcpg_pkg::ST_M_UXDY;
            rcpg_pkg::ST_M_UXDY:  if (w_mdone) n_state = rcpg_pkg::ST_M_SCALE;
            rcpg_pkg::ST_M_SCALE: if (w_mdone) n_state = rcpg_pkg::ST_COMMIT;
            rcpg_pkg::ST_COMMIT: begin
                n_state = (r_level < w_dl) ? rcpg_pkg::ST_CHECK : rcpg_pkg::ST_OUT;
            end
            rcpg_pkg::ST_OUT:     n_state = rcpg_pkg::ST_IDLE;
            default:              n_state = rcpg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcpg_pkg::ST_IDLE;
            r_mbusy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mdone) r_mbusy <= 1'b0;
            else if (w_mstart) r_mbusy <= 1'b1;
        end
    end

    // Frame stack and walk control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_fpos[l]   <= '0;
                r_fcx[l]    <= '0;
                r_fcy[l]    <= '0;
                r_fox[l]    <= '0;
                r_foy[l]    <= '0;
                r_fux[l]    <= '0;
                r_fuy[l]    <= '0;
                r_fflip[l]  <= 1'b0;
                r_fscale[l] <= '0;
            end
            r_level  <= '0;
            r_done   <= 1'b1;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (w_out_acc) r_ovalid <= 1'b0;
            case (r_state)
                rcpg_pkg::ST_IDLE: begin
                    if (w_in_acc && w_cmd == rcpg_pkg::CMD_RESTART) begin
                        r_level     <= '0;
                        r_fpos[0]   <= '0;
                        r_fcx[0]    <= '0;
                        r_fcy[0]    <= '0;
                        r_fox[0]    <= '0;
                        r_foy[0]    <= '0;
                        r_fux[0]    <= ONE;
                        r_fuy[0]    <= '0;
                        r_fflip[0]  <= 1'b0;
                        r_fscale[0] <= ONE;
                        r_done      <= 1'b0;
                    end
                end
                rcpg_pkg::ST_CHECK: begin
                    if (w_k >= w_n) begin
                        if (r_level == '0) begin
                            r_done  <= 1'b1;
                            r_olast <= 1'b1;
                        end else begin
                            r_level <= r_level - 1'b1;
                        end
                    end
                end
                rcpg_pkg::ST_COMMIT: begin
                    r_fcx[r_level]  <= f_sadd(w_cx, r_tdx);
                    r_fcy[r_level]  <= f_sadd(w_cy, r_dy);
                    r_fpos[r_level] <= w_k + 1'b1;
                    r_olast <= 1'b0;
                    if (r_level < w_dl) begin
                        r_fpos[r_level+1'b1]   <= '0;
                        r_fcx[r_level+1'b1]    <= '0;
                        r_fcy[r_level+1'b1]    <= '0;
                        r_fox[r_level+1'b1]    <= r_px;
                        r_foy[r_level+1'b1]    <= r_py;
                        r_fux[r_level+1'b1]    <= f_ssub(r_p0, r_p1);
                        r_fuy[r_level+1'b1]    <= f_sadd(r_p2, r_p3);
                        r_fflip[r_level+1'b1]  <= r_fflip[r_level] ^ r_tflip;
                        r_fscale[r_level+1'b1] <= w_mp;
                        r_level <= r_level + 1'b1;
                    end
                end
                rcpg_pkg::ST_OUT: begin
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Table read, product capture and output data.
    always_ff @(posedge i_clk) begin
        if (r_state == rcpg_pkg::ST_CHECK) r_raddr <= w_i;
        if (r_state == rcpg_pkg::ST_WAIT) begin
            r_tdx   <= w_rentry[CW-1:0];
            r_tdy   <= w_rentry[2*CW-1:CW];
            r_tflip <= w_rentry[2*CW];
            r_tvs   <= w_rentry[EW-1:2*CW+1];
        end
        if (w_mdone) begin
            case (r_state)
                rcpg_pkg::ST_M_DY:   r_dy <= w_mp;
                rcpg_pkg::ST_M_UXCX: r_p0 <= w_mp;
                rcpg_pkg::ST_M_UYCY: r_p1 <= w_mp;
                rcpg_pkg::ST_M_UYCX: r_p2 <= w_mp;
                rcpg_pkg::ST_M_UXCY: begin
                    r_px <= f_sadd(r_fox[r_level], f_ssub(r_p0, r_p1));
                    r_py <= f_sadd(r_foy[r_level], f_sadd(r_p2, w_mp));
                end
                rcpg_pkg::ST_M_UXDX: r_p0 <= w_mp;
                rcpg_pkg::ST_M_UYDY: r_p1 <= w_mp;
                rcpg_pkg::ST_M_UYDX: r_p2 <= w_mp;
                rcpg_pkg::ST_M_UXDY: r_p3 <= w_mp;
                default: ;
            endcase
        end
        if (r_state == rcpg_pkg::ST_CHECK && w_k >= w_n && r_level == '0) begin
            r_ox <= f_out(ONE);
            r_oy <= '0;
        end
        if (r_state == rcpg_pkg::ST_COMMIT) begin
            r_ox <= f_out(r_px);
            r_oy <= f_out(r_py);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

    // Assertions.
    `RCPG_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n,
        r_state != rcpg_pkg::ST_IDLE, !s_axis_tready, "input accepted while busy")
    `RCPG_ASSERT_NEXT(a_last_ends_walk, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast && m_axis_tready, r_done, "walk not ended on last")
    `RCPG_ASSERT_IMP(a_level_range, i_clk, i_rst_n,
        r_state != rcpg_pkg::ST_IDLE, r_level <= w_dl || r_state == rcpg_pkg::ST_CHECK,
        "level beyond depth limit")
endmodule
